// ===== hw/rtl/twc_pkg.sv =====
// Shared types and constants for the twist velocity clamp.
// No dependencies; the clamp, its lanes and the testbench import this package.
`default_nettype none
package twc_pkg;

  // Settings registers are unsigned Q16.16 values kept to 31 bits.
  localparam int unsigned CfgWidth = 31;
  localparam int unsigned CfgIdxWidth = 3;

  // Register indexes of the write port.
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_MAX_LIN   = 3'd0,
    CFG_MAX_ANG   = 3'd1,
    CFG_NOISE_LIN = 3'd2,
    CFG_NOISE_ANG = 3'd3
  } twc_cfg_idx_t;

  // Per-vector status reported with every word.
  typedef struct packed {
    logic zeroed;
    logic limited;
  } twc_flags_t;

endpackage
`default_nettype wire

// ===== hw/rtl/twc_in_if.sv =====
// Input channel of the twist velocity clamp: valid, ready and six components.
// No dependencies.
`default_nettype none
interface twc_in_if #(parameter int COMP_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] lin_x;
  logic signed [COMP_WIDTH-1:0] lin_y;
  logic signed [COMP_WIDTH-1:0] lin_z;
  logic signed [COMP_WIDTH-1:0] ang_x;
  logic signed [COMP_WIDTH-1:0] ang_y;
  logic signed [COMP_WIDTH-1:0] ang_z;

  modport source (output valid, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, input ready);
  modport sink   (input valid, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/twc_out_if.sv =====
// Result channel of the twist velocity clamp: six components and four flags.
// No dependencies.
`default_nettype none
interface twc_out_if #(parameter int COMP_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] out_lin_x;
  logic signed [COMP_WIDTH-1:0] out_lin_y;
  logic signed [COMP_WIDTH-1:0] out_lin_z;
  logic signed [COMP_WIDTH-1:0] out_ang_x;
  logic signed [COMP_WIDTH-1:0] out_ang_y;
  logic signed [COMP_WIDTH-1:0] out_ang_z;
  logic                         linear_zeroed;
  logic                         linear_limited;
  logic                         angular_zeroed;
  logic                         angular_limited;

  modport source (output valid, out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y,
                  out_ang_z, linear_zeroed, linear_limited, angular_zeroed,
                  angular_limited, input ready);
  modport sink   (input valid, out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y,
                  out_ang_z, linear_zeroed, linear_limited, angular_zeroed,
                  angular_limited, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/twist_velocity_clamp.sv =====
// Throughput: one word per cycle while the skid register is empty; the square root and the divide are fully pipelined,
// one bit per stage, in two lanes that run side by side, one per vector.
// A skid register behind the output register takes the next word while a result waits.
// Reset (synchronous, rst_n low) empties the pipeline and loads the settings defaults.
`default_nettype none
module twist_velocity_clamp import twc_pkg::*; #(
  parameter int COMP_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  twc_in_if.sink                 in_ch,
  twc_out_if.source              out_ch,
  input  logic                   cfg_wr_en,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]    cfg_wdata
);

  localparam int W   = COMP_WIDTH;
  // Register stages inside a lane: two front stages, the root stages, the
  // decision and product stages, and one stage per quotient bit.
  localparam int LAT = 2 * W + 5;

  // Settings registers. They are to be written only while the block is idle; the block does not enforce it.
  logic [CfgWidth-1:0] max_lin_r, max_ang_r, noise_lin_r, noise_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_lin_r   <= '1;
      max_ang_r   <= '1;
      noise_lin_r <= '0;
      noise_ang_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MAX_LIN:   max_lin_r   <= cfg_wdata;
        CFG_MAX_ANG:   max_ang_r   <= cfg_wdata;
        CFG_NOISE_LIN: noise_lin_r <= cfg_wdata;
        CFG_NOISE_ANG: noise_ang_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves as one while the skid register is empty.
  logic skid_v_r;
  logic en;
  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  // Valid bits ride alongside the lane stages.
  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  // Each lane takes its vector's three components as one small array.
  logic signed [W-1:0] lin_in [3];
  logic signed [W-1:0] ang_in [3];
  assign lin_in[0] = in_ch.lin_x;
  assign lin_in[1] = in_ch.lin_y;
  assign lin_in[2] = in_ch.lin_z;
  assign ang_in[0] = in_ch.ang_x;
  assign ang_in[1] = in_ch.ang_y;
  assign ang_in[2] = in_ch.ang_z;

  logic signed [W-1:0] lin_res [3];
  logic signed [W-1:0] ang_res [3];
  twc_flags_t          lin_flags, ang_flags;

  twc_lane #(.COMP_WIDTH(W)) u_lane_lin (
    .clk     (clk),
    .en      (en),
    .comp_i  (lin_in),
    .noise_i (noise_lin_r),
    .limit_i (max_lin_r),
    .comp_o  (lin_res),
    .flags_o (lin_flags)
  );

  twc_lane #(.COMP_WIDTH(W)) u_lane_ang (
    .clk     (clk),
    .en      (en),
    .comp_i  (ang_in),
    .noise_i (noise_ang_r),
    .limit_i (max_ang_r),
    .comp_o  (ang_res),
    .flags_o (ang_flags)
  );

  // Merge stage: the two lanes' results form one output word. The word goes
  // to the output register when it is free, otherwise into the skid register.
  logic                out_v_r;
  logic signed [W-1:0] o_lin_r [3];
  logic signed [W-1:0] o_ang_r [3];
  twc_flags_t          o_lf_r, o_af_r;
  logic signed [W-1:0] s_lin_r [3];
  logic signed [W-1:0] s_ang_r [3];
  twc_flags_t          s_lf_r, s_af_r;
  logic                slot_free;

  assign slot_free = !out_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (slot_free) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (vld_r[LAT-1]) begin
      if (slot_free) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (slot_free) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (slot_free) begin
        o_lin_r <= s_lin_r;
        o_ang_r <= s_ang_r;
        o_lf_r  <= s_lf_r;
        o_af_r  <= s_af_r;
      end
    end else if (vld_r[LAT-1]) begin
      if (slot_free) begin
        o_lin_r <= lin_res;
        o_ang_r <= ang_res;
        o_lf_r  <= lin_flags;
        o_af_r  <= ang_flags;
      end else begin
        s_lin_r <= lin_res;
        s_ang_r <= ang_res;
        s_lf_r  <= lin_flags;
        s_af_r  <= ang_flags;
      end
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.out_lin_x       = o_lin_r[0];
  assign out_ch.out_lin_y       = o_lin_r[1];
  assign out_ch.out_lin_z       = o_lin_r[2];
  assign out_ch.out_ang_x       = o_ang_r[0];
  assign out_ch.out_ang_y       = o_ang_r[1];
  assign out_ch.out_ang_z       = o_ang_r[2];
  assign out_ch.linear_zeroed   = o_lf_r.zeroed;
  assign out_ch.linear_limited  = o_lf_r.limited;
  assign out_ch.angular_zeroed  = o_af_r.zeroed;
  assign out_ch.angular_limited = o_af_r.limited;

`ifndef SYNTHESIS
  // The skid register only fills while the output register holds a word.
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid full with empty output");

  // A zeroed vector is never reported as limited.
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(o_lf_r.zeroed && o_lf_r.limited) && !(o_af_r.zeroed && o_af_r.limited))
    else $error("zeroed and limited together");

  // A zeroed linear vector leaves all three components at zero.
  a_lin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && o_lf_r.zeroed) |-> (o_lin_r[0] == '0 && o_lin_r[1] == '0 && o_lin_r[2] == '0))
    else $error("zeroed linear vector not zero");

  // While the skid holds a word, the pipeline does not advance.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(skid_v_r) && skid_v_r |-> $stable(vld_r)) else $error("pipeline moved on stall");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/twc_lane.sv =====
// One vector lane: squares, pipelined integer square root, deadzone and limit
// decision, scale product and pipelined restoring divide. Uses twc_pkg.
`default_nettype none
module twc_lane import twc_pkg::*; #(
  parameter int COMP_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COMP_WIDTH-1:0] comp_i [3],
  input  logic        [CfgWidth-1:0]   noise_i,
  input  logic        [CfgWidth-1:0]   limit_i,
  output logic signed [COMP_WIDTH-1:0] comp_o [3],
  output twc_flags_t                   flags_o
);

  localparam int W  = COMP_WIDTH;
  localparam int RW = W + 1;          // norm width
  localparam int SW = 2 * W + 3;      // square sum and root remainder width
  localparam int PW = 2 * W + 1;      // product and divide remainder width
  localparam int CW = ((RW > CfgWidth + 1) ? RW : CfgWidth + 1) + 1;

  // Stage 0: magnitudes and squares.
  logic [W-1:0]   mag0_r [3];
  logic [2*W-1:0] sq0_r  [3];
  logic [2:0]     neg0_r;
  // Stage 1: sum of squares.
  logic [W-1:0]   mag1_r [3];
  logic [SW-1:0]  sum1_r;
  logic [2:0]     neg1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        logic [W-1:0] m;
        m = comp_i[c][W-1] ? W'(-comp_i[c]) : W'(comp_i[c]);
        neg0_r[c] <= comp_i[c][W-1];
        mag0_r[c] <= m;
        sq0_r[c]  <= (2*W)'(m) * (2*W)'(m);
      end
      mag1_r <= mag0_r;
      neg1_r <= neg0_r;
      sum1_r <= SW'(sq0_r[0]) + SW'(sq0_r[1]) + SW'(sq0_r[2]);
    end
  end

  // Square root, one result bit per stage, most significant first.
  logic [SW-1:0] rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [W-1:0]  magq_r [RW][3];
  logic [2:0]    negq_r [RW];

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    localparam int B = W - j;
    logic [SW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [SW-1:0] trial;
    logic [W-1:0]  mq_in [3];
    logic [2:0]    nq_in;
    if (j == 0) begin : g_first
      assign rem_in  = sum1_r;
      assign root_in = '0;
      assign mq_in   = mag1_r;
      assign nq_in   = neg1_r;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign mq_in   = magq_r[j-1];
      assign nq_in   = negq_r[j-1];
    end
    assign trial = (SW'(root_in) << (B + 1)) + (SW'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_r[j]  <= rem_in - trial;
          root_r[j] <= root_in | (RW'(1) << B);
        end else begin
          rem_r[j]  <= rem_in;
          root_r[j] <= root_in;
        end
        magq_r[j] <= mq_in;
        negq_r[j] <= nq_in;
      end
    end
  end

  // Decision on the finished norm.
  logic [RW-1:0] norm;
  logic          dz;
  logic          lim;
  logic [RW-1:0] rnorm;
  logic [RW-1:0] kval;

  assign norm  = root_r[RW-1];
  assign dz    = (noise_i != '0) && (CW'(norm) < (CW'(noise_i) << 1));
  assign rnorm = (noise_i != '0) ? norm - RW'(noise_i) : norm;
  assign lim   = !dz && (CW'(rnorm) > CW'(limit_i));
  assign kval  = lim ? RW'(limit_i) : rnorm;

  logic [RW-1:0] normd_r;
  logic [RW-1:0] kd_r;
  logic [W-1:0]  magd_r [3];
  logic [2:0]    negd_r;
  logic          zd_r, ld_r, sd_r;
  // Product stage.
  logic [PW-1:0] prod_r [3];
  logic [RW-1:0] normp_r;
  logic [W-1:0]  magp_r [3];
  logic [2:0]    negp_r;
  logic          zp_r, lp_r, sp_r;

  always_ff @(posedge clk) begin
    if (en) begin
      normd_r <= norm;
      kd_r    <= kval;
      magd_r  <= magq_r[RW-1];
      negd_r  <= negq_r[RW-1];
      zd_r    <= dz;
      ld_r    <= lim;
      sd_r    <= (noise_i != '0) || lim;
      for (int c = 0; c < 3; c++) begin
        prod_r[c] <= PW'(magd_r[c]) * PW'(kd_r);
      end
      normp_r <= normd_r;
      magp_r  <= magd_r;
      negp_r  <= negd_r;
      zp_r    <= zd_r;
      lp_r    <= ld_r;
      sp_r    <= sd_r;
    end
  end

  // Restoring divide by the norm, one quotient bit per stage.
  logic [PW-1:0] rm_r   [W][3];
  logic [W-1:0]  q_r    [W][3];
  logic [RW-1:0] normv_r[W];
  logic [W-1:0]  magv_r [W][3];
  logic [2:0]    negv_r [W];
  logic          zv_r   [W];
  logic          lv_r   [W];
  logic          sv_r   [W];

  for (genvar j = 0; j < W; j++) begin : g_div
    localparam int I = W - 1 - j;
    logic [PW-1:0] rm_in [3];
    logic [W-1:0]  q_in  [3];
    logic [RW-1:0] nm_in;
    logic [PW-1:0] dsh;
    logic [W-1:0]  mv_in [3];
    logic [2:0]    nv_in;
    logic          zv_in, lv_in, sv_in;
    if (j == 0) begin : g_first
      assign rm_in = prod_r;
      assign q_in  = '{default: '0};
      assign nm_in = normp_r;
      assign mv_in = magp_r;
      assign nv_in = negp_r;
      assign zv_in = zp_r;
      assign lv_in = lp_r;
      assign sv_in = sp_r;
    end else begin : g_next
      assign rm_in = rm_r[j-1];
      assign q_in  = q_r[j-1];
      assign nm_in = normv_r[j-1];
      assign mv_in = magv_r[j-1];
      assign nv_in = negv_r[j-1];
      assign zv_in = zv_r[j-1];
      assign lv_in = lv_r[j-1];
      assign sv_in = sv_r[j-1];
    end
    assign dsh = PW'(nm_in) << I;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int c = 0; c < 3; c++) begin
          if (rm_in[c] >= dsh) begin
            rm_r[j][c] <= rm_in[c] - dsh;
            q_r[j][c]  <= q_in[c] | (W'(1) << I);
          end else begin
            rm_r[j][c] <= rm_in[c];
            q_r[j][c]  <= q_in[c];
          end
        end
        normv_r[j] <= nm_in;
        magv_r[j]  <= mv_in;
        negv_r[j]  <= nv_in;
        zv_r[j]    <= zv_in;
        lv_r[j]    <= lv_in;
        sv_r[j]    <= sv_in;
      end
    end
  end

  // Reapply the signs and the deadzone.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [W-1:0] m;
      m = sv_r[W-1] ? q_r[W-1][c] : magv_r[W-1][c];
      if (zv_r[W-1]) begin
        comp_o[c] = '0;
      end else begin
        comp_o[c] = negv_r[W-1][c] ? signed'(W'(-m)) : signed'(m);
      end
    end
    flags_o.zeroed  = zv_r[W-1];
    flags_o.limited = lv_r[W-1];
  end

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for twist_velocity_clamp: random and directed twists
// with idling on both channels. Depends on twc_pkg, twc_in_if, twc_out_if and the block.
`timescale 1ns / 1ps
module tb;
  import twc_pkg::*;

  localparam int CW = 32;
  localparam int PIPE_CYCLES = 2 * CW + 6;
  localparam int IDLE_LIMIT = 4000;
  // An index beyond the last register; the block must ignore writes to it.
  localparam logic [CfgIdxWidth-1:0] CFG_UNUSED_IDX = 3'd5;

  typedef logic [2:0][CW-1:0] vec3_t;

  // One conditioned twist: six components and the four status flags.
  typedef struct packed {
    vec3_t lin;
    vec3_t ang;
    logic  lin_zero;
    logic  lin_lim;
    logic  ang_zero;
    logic  ang_lim;
  } twist_out_t;

  // Keeps its own copy of the settings, predicts every conditioned twist and
  // compares the words leaving the block against them in order.
  class twist_scoreboard;
    logic [CfgWidth-1:0] max_lin, max_ang, noise_lin, noise_ang;
    twist_out_t          expected_twists[$];
    int                  errors;

    function new();
      max_lin = '1;
      max_ang = '1;
      noise_lin = '0;
      noise_ang = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] val);
      case (idx)
        CFG_MAX_LIN:   max_lin = val;
        CFG_MAX_ANG:   max_ang = val;
        CFG_NOISE_LIN: noise_lin = val;
        CFG_NOISE_ANG: noise_ang = val;
        default: ;
      endcase
    endfunction

    // Deadzone, shrink and limit of one 3-vector.
    function void shape_vector(input vec3_t v, input logic [CfgWidth-1:0] noise,
                               input logic [CfgWidth-1:0] limit, output vec3_t o,
                               output logic zeroed, output logic limited);
      vec3_t        mag;
      logic [2:0]   neg;
      logic [65:0]  sumsq;
      logic [32:0]  root, trial, rnorm, k;
      logic         scale;
      logic [127:0] q;
      sumsq = '0;
      for (int i = 0; i < 3; i++) begin
        neg[i] = v[i][CW-1];
        mag[i] = neg[i] ? -v[i] : v[i];
        sumsq += 66'(mag[i]) * 66'(mag[i]);
      end
      root = '0;
      for (int b = 32; b >= 0; b--) begin
        trial = root | (33'd1 << b);
        if (66'(trial) * 66'(trial) <= sumsq) root = trial;
      end
      zeroed = 1'b0;
      limited = 1'b0;
      scale = 1'b0;
      k = root;
      rnorm = root;
      o = '0;
      if (noise != 0) begin
        if (34'(root) < 34'(noise) * 2) begin
          zeroed = 1'b1;
          return;
        end
        rnorm = root - 33'(noise);
        k = rnorm;
        scale = 1'b1;
      end
      if (rnorm > 33'(limit)) begin
        limited = 1'b1;
        k = 33'(limit);
        scale = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
        q = scale ? (128'(mag[i]) * 128'(k)) / 128'(root) : 128'(mag[i]);
        o[i] = neg[i] ? -q[CW-1:0] : q[CW-1:0];
      end
    endfunction

    function void note_twist(vec3_t lin, vec3_t ang);
      twist_out_t e;
      shape_vector(lin, noise_lin, max_lin, e.lin, e.lin_zero, e.lin_lim);
      shape_vector(ang, noise_ang, max_ang, e.ang, e.ang_zero, e.ang_lim);
      expected_twists.push_back(e);
    endfunction

    task report(string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
    endtask

    task check_twist(twist_out_t got);
      twist_out_t e;
      if (expected_twists.size() == 0) begin
        report("result word with no twist outstanding");
        return;
      end
      e = expected_twists.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (got.lin[i] !== e.lin[i])
          report($sformatf("lin[%0d] got %h exp %h", i, got.lin[i], e.lin[i]));
        if (got.ang[i] !== e.ang[i])
          report($sformatf("ang[%0d] got %h exp %h", i, got.ang[i], e.ang[i]));
      end
      if (got.lin_zero !== e.lin_zero) report("linear_zeroed");
      if (got.lin_lim !== e.lin_lim) report("linear_limited");
      if (got.ang_zero !== e.ang_zero) report("angular_zeroed");
      if (got.ang_lim !== e.ang_lim) report("angular_limited");
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CfgIdxWidth-1:0] cfg_index;
  logic [CfgWidth-1:0] cfg_wdata;

  twc_in_if  #(.COMP_WIDTH(CW)) in_if ();
  twc_out_if #(.COMP_WIDTH(CW)) out_if ();

  twist_velocity_clamp #(.COMP_WIDTH(CW)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  twist_scoreboard sb = new();

  // The receiver reads these: a requested long hold-off and its ready pattern.
  int hold_request = 0;
  int ready_mode = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // All block inputs start at known values; the word fields are filled per item.
  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    {in_if.lin_x, in_if.lin_y, in_if.lin_z} = '0;
    {in_if.ang_x, in_if.ang_y, in_if.ang_z} = '0;
    out_if.ready = 1'b0;
  end

  // Monitor: every accepted input word is predicted and every accepted result
  // word is checked, both sampled at the rising edge.
  always @(posedge clk) begin
    twist_out_t got;
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        sb.note_twist({in_if.lin_z, in_if.lin_y, in_if.lin_x},
                      {in_if.ang_z, in_if.ang_y, in_if.ang_x});
      if (out_if.valid && out_if.ready) begin
        got.lin = {out_if.out_lin_z, out_if.out_lin_y, out_if.out_lin_x};
        got.ang = {out_if.out_ang_z, out_if.out_ang_y, out_if.out_ang_x};
        got.lin_zero = out_if.linear_zeroed;
        got.lin_lim = out_if.linear_limited;
        got.ang_zero = out_if.angular_zeroed;
        got.ang_lim = out_if.angular_limited;
        sb.check_twist(got);
      end
    end
  end

  // Watchdog: too many cycles with no word moving on either channel is a hang.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: changes ready at the falling edge. A requested hold-off keeps
  // ready low until its count, kept here, runs out, so that the pipeline and the
  // skid register fill and the input side backs up.
  initial begin
    int left;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        left = hold_request;
        hold_request = 0;
      end
      if (left > 0) begin
        out_if.ready = 1'b0;
        left--;
      end else begin
        case (ready_mode)
          0: out_if.ready = 1'b1;
          1: out_if.ready = ($urandom_range(0, 1) == 1);
          2: out_if.ready = ($urandom_range(0, 9) == 0);
          default: out_if.ready = ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Offers one word and returns at the rising edge at which it is taken.
  // Valid stays high when the next word follows straight away.
  task send_twist(vec3_t lin, vec3_t ang);
    @(negedge clk);
    in_if.valid = 1'b1;
    {in_if.lin_z, in_if.lin_y, in_if.lin_x} = lin;
    {in_if.ang_z, in_if.ang_y, in_if.ang_x} = ang;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task idle_input(int cycles);
    @(negedge clk);
    in_if.valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Waits until every predicted word has come back, then lets the pipeline
  // settle so a settings write cannot touch a word in flight.
  task drain();
    idle_input(0);
    while (sb.expected_twists.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES + 10) @(negedge clk);
  endtask

  task write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task write_all(logic [CfgWidth-1:0] ml, logic [CfgWidth-1:0] ma,
                 logic [CfgWidth-1:0] nl, logic [CfgWidth-1:0] na);
    write_reg(CFG_MAX_LIN, ml);
    write_reg(CFG_MAX_ANG, ma);
    write_reg(CFG_NOISE_LIN, nl);
    write_reg(CFG_NOISE_ANG, na);
  endtask

  // Component values: mostly small so that noise and limits matter, with
  // full-range words and the extremes mixed in.
  function logic [CW-1:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return 32'(signed'($urandom_range(0, 1 << 19)) - (1 << 18));
      2: return 32'(signed'($urandom_range(0, 1 << 25)) - (1 << 24));
      3: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          3: return 32'd1;
          default: return '0;
        endcase
      end
      4: return '0;
      default: return 32'(signed'($urandom_range(0, 1 << 21)) - (1 << 20));
    endcase
  endfunction

  function vec3_t rand_vec();
    vec3_t v;
    for (int i = 0; i < 3; i++) v[i] = rand_comp();
    return v;
  endfunction

  // Hand-picked twists: zero, the extremes, single axes, mixed signs and the
  // deadzone boundary where the norm is exactly twice the noise level.
  task send_directed();
    send_twist('0, '0);
    send_twist({3{32'h7fff_ffff}}, {3{32'h8000_0000}});
    send_twist({3{32'h8000_0000}}, {3{32'h7fff_ffff}});
    send_twist({32'd0, 32'd0, 32'h0002_0000}, {32'h0002_0000, 32'd0, 32'd0});
    send_twist({32'd0, 32'h0001_ffff, 32'd0}, {32'd0, 32'hfffe_0000, 32'd0});
    send_twist({32'h0003_0000, 32'hfffc_0000, 32'd0}, {32'd1, 32'hffff_ffff, 32'd1});
    send_twist({32'hffff_ffff, 32'd0, 32'd0}, '0);
    send_twist({32'h0010_0000, 32'hfff0_0000, 32'h0010_0000},
               {32'h8000_0000, 32'd0, 32'd0});
    send_twist({32'h0000_8000, 32'h0000_8000, 32'h0000_8000},
               {32'h0004_0000, 32'h0003_0000, 32'd0});
    send_twist({32'h7fff_ffff, 32'd0, 32'd0}, {32'd0, 32'd0, 32'hffff_0000});
  endtask

  task send_random(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && count > 0) begin
        send_twist(rand_vec(), rand_vec());
        burst--;
        count--;
      end
      if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 8));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Defaults after reset: no noise, widest limits.
    ready_mode = 0;
    send_directed();
    send_random(60);
    drain();

    // Zero maximum on both vectors; the ignored index must change nothing.
    write_all('0, '0, '0, '0);
    write_reg(CFG_UNUSED_IDX, 31'h0001_0000);
    ready_mode = 1;
    send_random(60);
    drain();

    // Largest noise everywhere, with a long receiver hold-off while the
    // sender keeps offering words, so the block fills and stalls its input.
    write_all('1, '1, '1, '1);
    hold_request = 400;
    send_random(120);
    drain();

    // Moderate settings that put the directed twists on every branch.
    write_all(31'h0003_0000, 31'h0000_8000, 31'h0001_0000, 31'h0000_4000);
    ready_mode = 3;
    send_directed();
    send_random(60);
    // The sender pauses until every result is back, then carries on.
    drain();
    send_random(40);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 0)
        write_all(CfgWidth'($urandom()), CfgWidth'($urandom()),
                  CfgWidth'($urandom()), CfgWidth'($urandom()));
      else
        write_all(CfgWidth'($urandom_range(0, 1 << 22)),
                  CfgWidth'($urandom_range(0, 1 << 22)),
                  CfgWidth'($urandom_range(0, 1 << 18)),
                  CfgWidth'($urandom_range(0, 1 << 18)));
      ready_mode = phase % 4;
      send_random(55);
      drain();
    end

    if (sb.expected_twists.size() != 0) sb.report("results still outstanding");
    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
